@@ rtl/iflsq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the inverse-frequency fit.
// No dependencies; used by iflsq_alu and inverse_frequency_lsq_fit_top.
package iflsq_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int MIN_POINTS  = 3;
    localparam int BIG_W       = 256;
    localparam int ITER_W      = $clog2(BIG_W);
    localparam int SHORT_LEN   = 49;
    localparam int SHORT_SHIFT = BIG_W - SHORT_LEN;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 136;
    localparam int STEP_W      = 5;

    localparam logic [STEP_W-1:0] STEP_LAST_POINT = 5'd3;
    localparam logic [STEP_W-1:0] STEP_FIRST_FIT  = 5'd4;
    localparam logic [STEP_W-1:0] STEP_V          = 5'd15;
    localparam logic [STEP_W-1:0] STEP_DEN        = 5'd18;
    localparam logic [STEP_W-1:0] STEP_LAST       = 5'd20;

    localparam logic [16:0] R2_ONE = 17'd65536;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FEW      = 2'd1,
        ST_ZERO_DEN = 2'd2
    } t_fit_status;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [2:0] {
        AS_IDLE,
        AS_MUL,
        AS_DIV_A,
        AS_DIV_B,
        AS_DIV,
        AS_DIV_Q,
        AS_SUB,
        AS_DONE
    } t_alu_state;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_ISSUE,
        SQ_WAIT,
        SQ_EMIT
    } t_seq_state;

    typedef enum logic [3:0] {
        SRC_ONE,
        SRC_F,
        SRC_MAG,
        SRC_RAT,
        SRC_N,
        SRC_A,
        SRC_B,
        SRC_R,
        SRC_S,
        SRC_T,
        SRC_X,
        SRC_P,
        SRC_D,
        SRC_NS,
        SRC_NO,
        SRC_V
    } t_src;

    typedef enum logic [1:0] {
        SH_0,
        SH_16,
        SH_32,
        SH_48
    } t_shift;

    typedef enum logic [3:0] {
        DST_SUMB,
        DST_SUMA,
        DST_SUMT,
        DST_SUMS,
        DST_X,
        DST_P,
        DST_D,
        DST_NS,
        DST_NO,
        DST_V,
        DST_OFF,
        DST_SLOPE,
        DST_R2
    } t_dst;

    typedef struct packed {
        t_alu_op op;
        t_src    src_a;
        t_shift  sh_a;
        t_src    src_b;
        t_dst    dst;
        logic    short_div;
    } t_uop;

    typedef struct packed {
        logic    start;
        t_alu_op op;
        logic    short_div;
    } t_alu_req;

    function automatic t_uop f_mk_uop(input t_alu_op op, input t_src a, input t_shift sh,
                                      input t_src b, input t_dst d, input logic sd);
        t_uop u;
        u.op        = op;
        u.src_a     = a;
        u.sh_a      = sh;
        u.src_b     = b;
        u.dst       = d;
        u.short_div = sd;
        return u;
    endfunction

    // per point: steps 0..3, fit: steps 4..20
    function automatic t_uop f_uop(input logic [STEP_W-1:0] step);
        t_uop u;
        unique case (step)
            5'd0:    u = f_mk_uop(ALU_DIV, SRC_ONE, SH_48, SRC_F,   DST_SUMB,  1'b1);
            5'd1:    u = f_mk_uop(ALU_DIV, SRC_X,   SH_0,  SRC_F,   DST_SUMA,  1'b1);
            5'd2:    u = f_mk_uop(ALU_DIV, SRC_RAT, SH_16, SRC_F,   DST_SUMT,  1'b1);
            5'd3:    u = f_mk_uop(ALU_MUL, SRC_MAG, SH_0,  SRC_MAG, DST_SUMS,  1'b0);
            5'd4:    u = f_mk_uop(ALU_MUL, SRC_A,   SH_48, SRC_N,   DST_X,     1'b0);
            5'd5:    u = f_mk_uop(ALU_MUL, SRC_B,   SH_0,  SRC_B,   DST_P,     1'b0);
            5'd6:    u = f_mk_uop(ALU_SUB, SRC_X,   SH_0,  SRC_P,   DST_D,     1'b0);
            5'd7:    u = f_mk_uop(ALU_MUL, SRC_T,   SH_32, SRC_N,   DST_X,     1'b0);
            5'd8:    u = f_mk_uop(ALU_MUL, SRC_R,   SH_0,  SRC_B,   DST_P,     1'b0);
            5'd9:    u = f_mk_uop(ALU_SUB, SRC_X,   SH_0,  SRC_P,   DST_NS,    1'b0);
            5'd10:   u = f_mk_uop(ALU_MUL, SRC_R,   SH_16, SRC_A,   DST_X,     1'b0);
            5'd11:   u = f_mk_uop(ALU_MUL, SRC_T,   SH_0,  SRC_B,   DST_P,     1'b0);
            5'd12:   u = f_mk_uop(ALU_SUB, SRC_X,   SH_0,  SRC_P,   DST_NO,    1'b0);
            5'd13:   u = f_mk_uop(ALU_MUL, SRC_S,   SH_16, SRC_N,   DST_X,     1'b0);
            5'd14:   u = f_mk_uop(ALU_MUL, SRC_R,   SH_0,  SRC_R,   DST_P,     1'b0);
            5'd15:   u = f_mk_uop(ALU_SUB, SRC_X,   SH_0,  SRC_P,   DST_V,     1'b0);
            5'd16:   u = f_mk_uop(ALU_DIV, SRC_NO,  SH_32, SRC_D,   DST_OFF,   1'b0);
            5'd17:   u = f_mk_uop(ALU_DIV, SRC_NS,  SH_48, SRC_D,   DST_SLOPE, 1'b0);
            5'd18:   u = f_mk_uop(ALU_MUL, SRC_D,   SH_0,  SRC_V,   DST_X,     1'b0);
            5'd19:   u = f_mk_uop(ALU_MUL, SRC_NS,  SH_16, SRC_NS,  DST_P,     1'b0);
            5'd20:   u = f_mk_uop(ALU_DIV, SRC_P,   SH_0,  SRC_X,   DST_R2,    1'b0);
            default: u = f_mk_uop(ALU_SUB, SRC_X,   SH_0,  SRC_X,   DST_X,     1'b0);
        endcase
        return u;
    endfunction

    function automatic logic [47:0] f_sat48(input logic [BIG_W-1:0] q);
        logic [47:0] v;
        if (q[BIG_W-1:47] == '0 || q[BIG_W-1:47] == '1) begin
            v = q[47:0];
        end else begin
            v = q[BIG_W-1] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        return v;
    endfunction

    function automatic logic [63:0] f_sat64(input logic [BIG_W-1:0] q);
        logic [63:0] v;
        if (q[BIG_W-1:63] == '0 || q[BIG_W-1:63] == '1) begin
            v = q[63:0];
        end else begin
            v = q[BIG_W-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return v;
    endfunction

    // quotient is never negative here
    function automatic logic [16:0] f_clamp_r2(input logic [BIG_W-1:0] q);
        logic [16:0] v;
        if (q[BIG_W-1:17] != '0 || q[16:0] > R2_ONE) begin
            v = R2_ONE;
        end else begin
            v = q[16:0];
        end
        return v;
    endfunction

endpackage

@@ rtl/iflsq_alu.sv @@
`timescale 1ns / 1ps
// Shared 256-bit multiply / divide / subtract unit, one add or subtract per cycle.
// Depends on iflsq_pkg.
module iflsq_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  iflsq_pkg::t_alu_req           i_req,
    input  logic [iflsq_pkg::BIG_W-1:0]   i_opa,
    input  logic [iflsq_pkg::BIG_W-1:0]   i_opb,
    output logic                          o_done,
    output logic [iflsq_pkg::BIG_W-1:0]   o_result
);
    import iflsq_pkg::*;

    t_alu_state        r_state, n_state;
    t_alu_op           r_op, n_op;
    logic              r_short, n_short;
    logic              r_neg, n_neg;
    logic [ITER_W-1:0] r_cnt, n_cnt;
    logic [BIG_W-1:0]  r_x, n_x;
    logic [BIG_W-1:0]  r_y, n_y;
    logic [BIG_W-1:0]  r_z, n_z;

    logic [BIG_W:0]    w_ax, w_ay;
    logic              w_sub;
    logic [BIG_W+1:0]  w_sum;
    logic              w_ge;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            AS_IDLE: begin
                if (i_req.start) begin
                    unique case (i_req.op)
                        ALU_MUL: n_state = AS_MUL;
                        ALU_DIV: n_state = AS_DIV_A;
                        ALU_SUB: n_state = AS_SUB;
                        default: n_state = AS_IDLE;
                    endcase
                end
            end
            AS_MUL:   if (r_z == '0) n_state = AS_DONE;
            AS_DIV_A: n_state = AS_DIV_B;
            AS_DIV_B: n_state = AS_DIV;
            AS_DIV:   if (r_cnt == '0) n_state = r_neg ? AS_DIV_Q : AS_DONE;
            AS_DIV_Q: n_state = AS_DONE;
            AS_SUB:   n_state = AS_DONE;
            AS_DONE:  n_state = AS_IDLE;
            default:  n_state = AS_IDLE;
        endcase
    end

    // single adder shared by every operation
    always_comb begin
        w_ax  = '0;
        w_ay  = '0;
        w_sub = 1'b1;
        unique case (r_state)
            AS_MUL: begin
                w_ax  = {1'b0, r_x};
                w_ay  = {1'b0, r_y};
                w_sub = 1'b0;
            end
            AS_DIV_A: w_ay = {1'b0, r_z};
            AS_DIV_B: w_ay = {1'b0, r_y};
            AS_DIV: begin
                w_ax = {r_x, r_z[BIG_W-1]};
                w_ay = {1'b0, r_y};
            end
            AS_DIV_Q: w_ay = {1'b0, r_z};
            AS_SUB: begin
                w_ax = {1'b0, r_y};
                w_ay = {1'b0, r_z};
            end
            default: w_sub = 1'b1;
        endcase
    end

    assign w_sum = {1'b0, w_ax} + {1'b0, w_ay ^ {(BIG_W+1){w_sub}}} + (BIG_W+2)'(w_sub);
    assign w_ge  = w_sum[BIG_W+1];

    always_comb begin
        n_op    = r_op;
        n_short = r_short;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        unique case (r_state)
            AS_IDLE: begin
                if (i_req.start) begin
                    n_op    = i_req.op;
                    n_short = i_req.short_div;
                    n_neg   = i_opa[BIG_W-1] ^ i_opb[BIG_W-1];
                    n_x     = '0;
                    n_y     = (i_req.op == ALU_DIV) ? i_opb : i_opa;
                    n_z     = (i_req.op == ALU_DIV) ? i_opa : i_opb;
                end
            end
            AS_MUL: begin
                if (r_z != '0) begin
                    if (r_z[0]) n_x = w_sum[BIG_W-1:0];
                    n_y = {r_y[BIG_W-2:0], 1'b0};
                    n_z = {1'b0, r_z[BIG_W-1:1]};
                end
            end
            AS_DIV_A: if (r_z[BIG_W-1]) n_z = w_sum[BIG_W-1:0];
            AS_DIV_B: begin
                if (r_y[BIG_W-1]) n_y = w_sum[BIG_W-1:0];
                n_x   = '0;
                n_z   = r_short ? (r_z << SHORT_SHIFT) : r_z;
                n_cnt = r_short ? ITER_W'(SHORT_LEN - 1) : ITER_W'(BIG_W - 1);
            end
            AS_DIV: begin
                n_x   = w_ge ? w_sum[BIG_W-1:0] : {r_x[BIG_W-2:0], r_z[BIG_W-1]};
                n_z   = {r_z[BIG_W-2:0], w_ge};
                n_cnt = r_cnt - 1'b1;
            end
            AS_DIV_Q: n_z = w_sum[BIG_W-1:0];
            AS_SUB:   n_x = w_sum[BIG_W-1:0];
            default:  n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= AS_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op    <= n_op;
        r_short <= n_short;
        r_neg   <= n_neg;
        r_cnt   <= n_cnt;
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
    end

    assign o_done   = (r_state == AS_DONE);
    assign o_result = (r_op == ALU_DIV) ? r_z : r_x;

endmodule

@@ rtl/inverse_frequency_lsq_fit_top.sv @@
`timescale 1ns / 1ps
// Inverse-frequency least-squares fit: sequencer, sums and stream ports.
// Depends on iflsq_pkg and iflsq_alu.

// Points enter one beat at a time and the block is not ready while one is
// being worked. Multiplications, divisions and subtractions run on a single
// shared 256-bit add/subtract unit, one iteration per cycle. A point takes
// three short divisions with a 49-bit quotient and a squaring of its 32-bit
// magnitude; a point beyond MAX_POINTS is not accumulated. The point flagged
// by tlast then runs the fit: three divisions with a 256-bit quotient and ten
// multiplications of one step per multiplier bit, all 256 bits when the
// multiplier is negative. A zero denominator ends the fit early. A finished
// result waits in the output register while the next point is taken.
module inverse_frequency_lsq_fit_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [23:0] freq_hz, [55:24] ratio
    input  logic [iflsq_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input  logic                               i_s_tlast,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [47:0] fit_offset, [111:48] fit_slope, [128:112] r_squared,
    // [130:129] fit_status, [135:131] zero
    output logic [iflsq_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import iflsq_pkg::*;

    t_seq_state        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [63:0]       r_sum_a, n_sum_a;
    logic [63:0]       r_sum_b, n_sum_b;
    logic [63:0]       r_sum_s, n_sum_s;
    logic [63:0]       r_sum_t, n_sum_t;
    logic [47:0]       r_sum_r, n_sum_r;
    logic [23:0]       r_f, n_f;
    logic [31:0]       r_mag, n_mag;
    logic [31:0]       r_rat, n_rat;
    logic              r_last, n_last;
    logic [BIG_W-1:0]  r_x, n_x;
    logic [BIG_W-1:0]  r_p, n_p;
    logic [BIG_W-1:0]  r_d, n_d;
    logic [BIG_W-1:0]  r_ns, n_ns;
    logic [BIG_W-1:0]  r_no, n_no;
    logic [BIG_W-1:0]  r_v, n_v;
    logic [47:0]       r_off, n_off;
    logic [63:0]       r_slope, n_slope;
    logic [16:0]       r_r2, n_r2;
    t_fit_status       r_status, n_status;
    logic              r_m_valid, n_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data, n_m_data;

    t_uop              w_uop;
    t_alu_req          w_req;
    logic [BIG_W-1:0]  w_opa, w_opb, w_res;
    logic              w_alu_done;
    logic              w_in_beat, w_room, w_few, w_out_free, w_fit_entry;
    logic [23:0]       w_f_in;
    logic [31:0]       w_rat_in, w_mag_in;

    function automatic logic [BIG_W-1:0] f_src(input t_src s);
        logic [BIG_W-1:0] v;
        unique case (s)
            SRC_ONE: v = BIG_W'(1);
            SRC_F:   v = BIG_W'(r_f);
            SRC_MAG: v = BIG_W'(r_mag);
            SRC_RAT: v = {{(BIG_W-32){r_rat[31]}}, r_rat};
            SRC_N:   v = BIG_W'(r_count);
            SRC_A:   v = BIG_W'(r_sum_a);
            SRC_B:   v = BIG_W'(r_sum_b);
            SRC_R:   v = {{(BIG_W-48){r_sum_r[47]}}, r_sum_r};
            SRC_S:   v = BIG_W'(r_sum_s);
            SRC_T:   v = {{(BIG_W-64){r_sum_t[63]}}, r_sum_t};
            SRC_X:   v = r_x;
            SRC_P:   v = r_p;
            SRC_D:   v = r_d;
            SRC_NS:  v = r_ns;
            SRC_NO:  v = r_no;
            SRC_V:   v = r_v;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [BIG_W-1:0] f_shift(input logic [BIG_W-1:0] v, input t_shift sh);
        logic [BIG_W-1:0] r;
        unique case (sh)
            SH_0:    r = v;
            SH_16:   r = v << 16;
            SH_32:   r = v << 32;
            SH_48:   r = v << 48;
            default: r = v;
        endcase
        return r;
    endfunction

    assign w_uop = f_uop(r_step);

    always_comb begin
        w_opa = f_shift(f_src(w_uop.src_a), w_uop.sh_a);
        w_opb = f_src(w_uop.src_b);
    end

    assign w_req.start     = (r_state == SQ_ISSUE);
    assign w_req.op        = w_uop.op;
    assign w_req.short_div = w_uop.short_div;

    iflsq_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_opa    (w_opa),
        .i_opb    (w_opb),
        .o_done   (w_alu_done),
        .o_result (w_res)
    );

    assign o_s_tready = (r_state == SQ_IDLE);
    assign w_in_beat  = i_s_tvalid && o_s_tready;
    assign w_room     = (r_count < CNT_W'(MAX_POINTS));
    assign w_few      = (r_count < CNT_W'(MIN_POINTS));
    assign w_out_free = !r_m_valid || i_m_tready;
    assign w_f_in     = (i_s_tdata[23:0] == '0) ? 24'd1 : i_s_tdata[23:0];
    assign w_rat_in   = i_s_tdata[55:24];
    assign w_mag_in   = w_rat_in[31] ? (~w_rat_in + 32'd1) : w_rat_in;

    assign w_fit_entry = (w_in_beat && !w_room && i_s_tlast)
                      || (r_state == SQ_WAIT && w_alu_done && r_step == STEP_LAST_POINT
                          && r_last);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            SQ_IDLE: begin
                if (w_in_beat) begin
                    if (w_room) begin
                        n_state = SQ_ISSUE;
                        n_step  = '0;
                    end else if (i_s_tlast) begin
                        n_state = w_few ? SQ_EMIT : SQ_ISSUE;
                        n_step  = STEP_FIRST_FIT;
                    end
                end
            end
            SQ_ISSUE: n_state = SQ_WAIT;
            SQ_WAIT: begin
                if (w_alu_done) begin
                    priority if (r_step == STEP_LAST_POINT) begin
                        if (!r_last) begin
                            n_state = SQ_IDLE;
                        end else if (w_few) begin
                            n_state = SQ_EMIT;
                        end else begin
                            n_state = SQ_ISSUE;
                            n_step  = STEP_FIRST_FIT;
                        end
                    end else if (r_step == STEP_V && r_d == '0) begin
                        n_state = SQ_EMIT;
                    end else if (r_step == STEP_DEN && (w_res == '0 || w_res[BIG_W-1])) begin
                        n_state = SQ_EMIT;
                    end else if (r_step == STEP_LAST) begin
                        n_state = SQ_EMIT;
                    end else begin
                        n_state = SQ_ISSUE;
                        n_step  = r_step + 1'b1;
                    end
                end
            end
            SQ_EMIT: if (w_out_free) n_state = SQ_IDLE;
            default: n_state = SQ_IDLE;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_sum_a   = r_sum_a;
        n_sum_b   = r_sum_b;
        n_sum_s   = r_sum_s;
        n_sum_t   = r_sum_t;
        n_sum_r   = r_sum_r;
        n_f       = r_f;
        n_mag     = r_mag;
        n_rat     = r_rat;
        n_last    = r_last;
        n_x       = r_x;
        n_p       = r_p;
        n_d       = r_d;
        n_ns      = r_ns;
        n_no      = r_no;
        n_v       = r_v;
        n_off     = r_off;
        n_slope   = r_slope;
        n_r2      = r_r2;
        n_status  = r_status;
        n_m_data  = r_m_data;
        n_m_valid = r_m_valid && !i_m_tready;

        if (w_in_beat) begin
            n_f    = w_f_in;
            n_rat  = w_rat_in;
            n_mag  = w_mag_in;
            n_last = i_s_tlast;
            if (w_room) begin
                n_count = r_count + 1'b1;
                n_sum_r = r_sum_r + {{16{w_rat_in[31]}}, w_rat_in};
            end
        end

        if (w_fit_entry) begin
            n_off    = '0;
            n_slope  = '0;
            n_r2     = '0;
            n_status = w_few ? ST_FEW : ST_OK;
        end

        if (r_state == SQ_WAIT && w_alu_done) begin
            unique case (w_uop.dst)
                DST_SUMB: begin
                    n_sum_b = r_sum_b + w_res[63:0];
                    n_x     = w_res;
                end
                DST_SUMA:  n_sum_a = r_sum_a + w_res[63:0];
                DST_SUMT:  n_sum_t = r_sum_t + w_res[63:0];
                DST_SUMS:  n_sum_s = r_sum_s + w_res[79:16];
                DST_X:     n_x     = w_res;
                DST_P:     n_p     = w_res;
                DST_D:     n_d     = w_res;
                DST_NS:    n_ns    = w_res;
                DST_NO:    n_no    = w_res;
                DST_V:     n_v     = w_res;
                DST_OFF:   n_off   = f_sat48(w_res);
                DST_SLOPE: n_slope = f_sat64(w_res);
                DST_R2:    n_r2    = f_clamp_r2(w_res);
                default:   n_x     = r_x;
            endcase
            if (r_step == STEP_V && r_d == '0) n_status = ST_ZERO_DEN;
        end

        if (r_state == SQ_EMIT && w_out_free) begin
            n_m_valid = 1'b1;
            n_m_data  = {5'd0, 2'(r_status), r_r2, r_slope, r_off};
            n_count   = '0;
            n_sum_a   = '0;
            n_sum_b   = '0;
            n_sum_s   = '0;
            n_sum_t   = '0;
            n_sum_r   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= SQ_IDLE;
            r_step    <= '0;
            r_count   <= '0;
            r_sum_a   <= '0;
            r_sum_b   <= '0;
            r_sum_s   <= '0;
            r_sum_t   <= '0;
            r_sum_r   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_count   <= n_count;
            r_sum_a   <= n_sum_a;
            r_sum_b   <= n_sum_b;
            r_sum_s   <= n_sum_s;
            r_sum_t   <= n_sum_t;
            r_sum_r   <= n_sum_r;
            r_m_valid <= n_m_valid;
        end
        r_f      <= n_f;
        r_mag    <= n_mag;
        r_rat    <= n_rat;
        r_last   <= n_last;
        r_x      <= n_x;
        r_p      <= n_p;
        r_d      <= n_d;
        r_ns     <= n_ns;
        r_no     <= n_no;
        r_v      <= n_v;
        r_off    <= n_off;
        r_slope  <= n_slope;
        r_r2     <= n_r2;
        r_status <= n_status;
        r_m_data <= n_m_data;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

`ifndef SYNTHESIS
    a_alu_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_done |-> (r_state == SQ_WAIT))
        else $error("alu finished outside of wait state");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count above limit");

    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SQ_EMIT && w_out_free) |=> (r_count == '0 && r_sum_a == '0
                                                && r_sum_t == '0))
        else $error("sums not cleared after fit");

    a_fail_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SQ_EMIT && w_out_free && r_status != ST_OK)
            |=> (o_m_tdata[128:0] == '0))
        else $error("failed fit carries nonzero fields");
`endif

endmodule
